>>> rtl/sdta_pkg.sv
// Shared types and constants of the state dwell-time accumulator.
package sdta_pkg;

  localparam int TIME_W      = 48;
  localparam int TOTAL_W     = 56;
  localparam int COARSE_BINS = 4;
  localparam int COARSE_W    = 2;
  localparam int VALUE_W     = 6;
  localparam int INDEX_W     = 9;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;
  localparam logic [1:0]         PHASE_SERVICE = 2'd1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_PHASE  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Engine sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RESP
  } eng_state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TIME_W-1:0]  event_time;
    logic [1:0]         phase;
    logic               queue_select;
    logic [VALUE_W-1:0] batch_size;
    logic [VALUE_W-1:0] queue_length;
    logic               read_fine;
    logic [INDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_time;
    logic               saturated;
    logic               bin_open;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } resp_t;

endpackage

>>> rtl/sdta_if.sv
// Valid/ready channel interfaces for input and result items.
interface sdta_in_if;
  import sdta_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sdta_out_if;
  import sdta_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/sdta_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module sdta_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 432
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/sdta_engine.sv
// Server state tracking and read-modify-write of the dwell totals in memory.
module sdta_engine #(
  parameter int FIRST_QUEUE_CAP  = 5,
  parameter int SECOND_QUEUE_CAP = 5,
  parameter int MAX_BATCH        = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdta_in_if.sink       in_i,
  output sdta_pkg::resp_t resp_o,
  input  logic          resp_ready_i
);
  import sdta_pkg::*;

  localparam int FINE_BINS = COARSE_BINS * (FIRST_QUEUE_CAP + 1) *
                             (SECOND_QUEUE_CAP + 1) * (MAX_BATCH + 1);
  localparam int FINE_W = $clog2(FINE_BINS);
  localparam logic [FINE_W-1:0] FINE_LAST = FINE_W'(FINE_BINS - 1);

  eng_state_e state_q, state_d;

  // Tracked server state
  logic [1:0]         phase_q, phase_d;
  logic               queue_q, queue_d;
  logic [VALUE_W-1:0] len_first_q, len_first_d;
  logic [VALUE_W-1:0] len_second_q, len_second_d;
  logic [VALUE_W-1:0] batch_q, batch_d;

  // Open bins
  logic                coarse_open_q;
  logic [COARSE_W-1:0] coarse_held_q;
  logic [TIME_W-1:0]   coarse_start_q;
  logic                fine_open_q;
  logic [FINE_W-1:0]   fine_held_q;
  logic [TIME_W-1:0]   fine_start_q;

  // Work registers between the read and the write-back
  logic                coarse_close_q, fine_close_q;
  logic [COARSE_W-1:0] coarse_wa_q;
  logic [FINE_W-1:0]   fine_wa_q;
  logic [TIME_W-1:0]   coarse_elapsed_q, fine_elapsed_q;
  logic                rd_fine_q, rd_hit_q, rd_open_q;
  logic [FINE_W-1:0]   clr_q;

  in_item_t            it;
  logic                accept, update, rd_item;
  logic                has_coarse, has_fine;
  logic [COARSE_W-1:0] coarse_n;
  logic [FINE_W-1:0]   fine_n;
  logic                coarse_change, fine_change;
  logic                coarse_close, fine_close;
  logic [TIME_W-1:0]   coarse_elapsed, fine_elapsed;
  logic                rd_hit, rd_open;

  logic                coarse_we, coarse_re, fine_we, fine_re;
  logic [COARSE_W-1:0] coarse_wa, coarse_ra;
  logic [FINE_W-1:0]   fine_wa, fine_ra;
  logic [TOTAL_W-1:0]  coarse_wd, fine_wd, coarse_rd, fine_rd;
  logic [TOTAL_W:0]    coarse_sum, fine_sum;
  logic [TOTAL_W-1:0]  rd_total;

  assign it      = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept  = in_i.valid && in_i.ready;
  assign update  = accept && (it.kind == KIND_PHASE || it.kind == KIND_LENGTH);
  assign rd_item = accept && (it.kind == KIND_READ);

  // Apply the update to the tracked state
  always_comb begin
    phase_d      = phase_q;
    queue_d      = queue_q;
    batch_d      = batch_q;
    len_first_d  = len_first_q;
    len_second_d = len_second_q;
    if (it.kind == KIND_PHASE) begin
      phase_d = it.phase;
      queue_d = it.queue_select;
      batch_d = it.batch_size;
    end else if (it.kind == KIND_LENGTH) begin
      if (it.queue_select) begin
        len_second_d = it.queue_length;
      end else begin
        len_first_d = it.queue_length;
      end
    end
  end

  // Bin numbers of the new state
  assign has_coarse = (phase_d <= PHASE_SERVICE);
  assign coarse_n   = {phase_d[0], queue_d};
  assign has_fine   = has_coarse &&
                      (len_first_d <= VALUE_W'(FIRST_QUEUE_CAP)) &&
                      (len_second_d <= VALUE_W'(SECOND_QUEUE_CAP)) &&
                      (batch_d <= VALUE_W'(MAX_BATCH));
  assign fine_n = ((FINE_W'(coarse_n) * FINE_W'(FIRST_QUEUE_CAP + 1) + FINE_W'(len_first_d))
                   * FINE_W'(SECOND_QUEUE_CAP + 1) + FINE_W'(len_second_d))
                  * FINE_W'(MAX_BATCH + 1) + FINE_W'(batch_d);

  // Decide which open bins close
  assign coarse_change = update &&
                         !(coarse_open_q && has_coarse && coarse_held_q == coarse_n);
  assign fine_change   = update && !(fine_open_q && has_fine && fine_held_q == fine_n);
  assign coarse_close  = coarse_change && coarse_open_q;
  assign fine_close    = fine_change && fine_open_q;

  // Elapsed time, zero when time runs backwards
  assign coarse_elapsed = (it.event_time > coarse_start_q) ?
                          it.event_time - coarse_start_q : '0;
  assign fine_elapsed   = (it.event_time > fine_start_q) ?
                          it.event_time - fine_start_q : '0;

  // Read lookup
  always_comb begin
    if (it.read_fine) begin
      rd_hit  = (32'(it.read_index) < FINE_BINS);
      rd_open = fine_open_q && (32'(fine_held_q) == 32'(it.read_index));
    end else begin
      rd_hit  = (it.read_index < INDEX_W'(COARSE_BINS));
      rd_open = coarse_open_q && (INDEX_W'(coarse_held_q) == it.read_index);
    end
  end

  // Memory ports
  assign coarse_re  = coarse_close || (rd_item && !it.read_fine);
  assign coarse_ra  = coarse_close ? coarse_held_q : it.read_index[COARSE_W-1:0];
  assign fine_re    = fine_close || (rd_item && it.read_fine);
  assign fine_ra    = fine_close ? fine_held_q : FINE_W'(it.read_index);

  assign coarse_sum = {1'b0, coarse_rd} + (TOTAL_W+1)'(coarse_elapsed_q);
  assign fine_sum   = {1'b0, fine_rd} + (TOTAL_W+1)'(fine_elapsed_q);

  assign coarse_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE && coarse_close_q);
  assign coarse_wa = (state_q == ST_CLEAR) ? clr_q[COARSE_W-1:0] : coarse_wa_q;
  assign coarse_wd = (state_q == ST_CLEAR) ? '0 :
                     (coarse_sum[TOTAL_W] ? TOTAL_MAX : coarse_sum[TOTAL_W-1:0]);
  assign fine_we   = (state_q == ST_CLEAR) || (state_q == ST_WRITE && fine_close_q);
  assign fine_wa   = (state_q == ST_CLEAR) ? clr_q : fine_wa_q;
  assign fine_wd   = (state_q == ST_CLEAR) ? '0 :
                     (fine_sum[TOTAL_W] ? TOTAL_MAX : fine_sum[TOTAL_W-1:0]);

  sdta_ram #(.WIDTH(TOTAL_W), .DEPTH(COARSE_BINS)) u_coarse_ram (
    .clk_i     (clk_i),
    .wr_en_i   (coarse_we),
    .wr_addr_i (coarse_wa),
    .wr_data_i (coarse_wd),
    .rd_en_i   (coarse_re),
    .rd_addr_i (coarse_ra),
    .rd_data_o (coarse_rd)
  );

  sdta_ram #(.WIDTH(TOTAL_W), .DEPTH(FINE_BINS)) u_fine_ram (
    .clk_i     (clk_i),
    .wr_en_i   (fine_we),
    .wr_addr_i (fine_wa),
    .wr_data_i (fine_wd),
    .rd_en_i   (fine_re),
    .rd_addr_i (fine_ra),
    .rd_data_o (fine_rd)
  );

  // Result of a read transfer
  assign rd_total = rd_hit_q ? (rd_fine_q ? fine_rd : coarse_rd) : '0;
  assign resp_o.valid           = (state_q == ST_RESP);
  assign resp_o.item.total_time = rd_total;
  assign resp_o.item.saturated  = (rd_total == TOTAL_MAX);
  assign resp_o.item.bin_open   = rd_open_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == FINE_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (update && (coarse_close || fine_close)) begin
          state_d = ST_WRITE;
        end else if (rd_item) begin
          state_d = ST_RESP;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_RESP: begin
        if (resp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + FINE_W'(1);
      end
    end
  end

  // Tracked state and open bins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= '0;
      queue_q        <= 1'b0;
      len_first_q    <= '0;
      len_second_q   <= '0;
      batch_q        <= '0;
      coarse_open_q  <= 1'b0;
      coarse_held_q  <= '0;
      coarse_start_q <= '0;
      fine_open_q    <= 1'b0;
      fine_held_q    <= '0;
      fine_start_q   <= '0;
    end else if (update) begin
      phase_q      <= phase_d;
      queue_q      <= queue_d;
      len_first_q  <= len_first_d;
      len_second_q <= len_second_d;
      batch_q      <= batch_d;
      if (coarse_change) begin
        coarse_open_q <= has_coarse;
        if (has_coarse) begin
          coarse_held_q  <= coarse_n;
          coarse_start_q <= it.event_time;
        end
      end
      if (fine_change) begin
        fine_open_q <= has_fine;
        if (has_fine) begin
          fine_held_q  <= fine_n;
          fine_start_q <= it.event_time;
        end
      end
    end
  end

  // Capture what the write-back and the response need
  always_ff @(posedge clk_i) begin
    if (accept) begin
      coarse_close_q   <= coarse_close;
      fine_close_q     <= fine_close;
      coarse_wa_q      <= coarse_held_q;
      fine_wa_q        <= fine_held_q;
      coarse_elapsed_q <= coarse_elapsed;
      fine_elapsed_q   <= fine_elapsed;
      rd_fine_q        <= it.read_fine;
      rd_hit_q         <= rd_hit;
      rd_open_q        <= rd_open;
    end
  end

`ifndef SYNTHESIS
  a_close_writes_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update && (coarse_close || fine_close)) |=> (state_q == ST_WRITE))
    else $error("closed bin not written back");
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (state_q == ST_IDLE))
    else $error("write-back longer than one cycle");
  a_fine_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fine_open_q |-> (32'(fine_held_q) < FINE_BINS))
    else $error("open fine bin out of range");
  a_read_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_item |=> resp_o.valid)
    else $error("read transfer without response");
`endif

endmodule

>>> rtl/state_dwell_time_accumulator_top.sv
// An update that closes a bin reads its total from memory, then writes it back (read-modify-write).
// A read transfer's total goes through the RAM read register, then the output register.
// Input is held off during a write-back or while a read result is pending, so a new item
// is taken only after the last one is done. A read result waits in the engine, stalling
// input, while the output register is full and not draining. After reset a clearing pass
// zeroes all totals (FINE_BINS fine, 432 at the defaults), during which no item is accepted.
module state_dwell_time_accumulator_top #(
  parameter int FIRST_QUEUE_CAP  = 5,
  parameter int SECOND_QUEUE_CAP = 5,
  parameter int MAX_BATCH        = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdta_in_if.sink    in_i,
  sdta_out_if.source out_o
);
  import sdta_pkg::*;

  resp_t     resp;
  logic      resp_ready;
  logic      out_valid_q;
  out_item_t out_data_q;

  sdta_engine #(
    .FIRST_QUEUE_CAP  (FIRST_QUEUE_CAP),
    .SECOND_QUEUE_CAP (SECOND_QUEUE_CAP),
    .MAX_BATCH        (MAX_BATCH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .resp_o       (resp),
    .resp_ready_i (resp_ready)
  );

  // Take a new result when the output register is empty or drains this cycle
  assign resp_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp.valid && resp_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until transfer
  always_ff @(posedge clk_i) begin
    if (resp.valid && resp_ready) begin
      out_data_q <= resp.item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

>>> dv/state_dwell_time_accumulator_top_tb.sv
// Self-checking testbench for the state dwell-time accumulator top level.
`timescale 1ns / 100ps

module state_dwell_time_accumulator_top_tb;
  import sdta_pkg::*;

  localparam int FIRST_CAP     = 5;
  localparam int SECOND_CAP    = 5;
  localparam int BATCH_CAP     = 2;
  localparam int FINE_BINS     = COARSE_BINS * (FIRST_CAP + 1) * (SECOND_CAP + 1) *
                                 (BATCH_CAP + 1);
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [TIME_W-1:0] LAST_TICK = '1;

  logic clk_i;
  logic rst_ni;

  sdta_in_if  in_if ();
  sdta_out_if out_if ();

  state_dwell_time_accumulator_top #(
    .FIRST_QUEUE_CAP  (FIRST_CAP),
    .SECOND_QUEUE_CAP (SECOND_CAP),
    .MAX_BATCH        (BATCH_CAP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Tracked server state and dwell bins
  logic [1:0]         cur_phase    = '0;
  logic               cur_queue    = 1'b0;
  logic [VALUE_W-1:0] len_first    = '0;
  logic [VALUE_W-1:0] len_second   = '0;
  logic [VALUE_W-1:0] cur_batch    = '0;
  logic               coarse_open  = 1'b0;
  logic [COARSE_W-1:0] coarse_bin  = '0;
  logic [TIME_W-1:0]  coarse_since = '0;
  logic               fine_open    = 1'b0;
  logic [INDEX_W-1:0] fine_bin     = '0;
  logic [TIME_W-1:0]  fine_since   = '0;
  logic [INDEX_W-1:0] recent_fine  = '0;
  logic [TOTAL_W-1:0] coarse_total [COARSE_BINS];
  logic [TOTAL_W-1:0] fine_total   [FINE_BINS];

  out_item_t         expected_totals [$];
  out_item_t         want;
  logic [TIME_W-1:0] stamp = '0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  logic              holding = 1'b0;
  event              hold_off_ev;
  int                errors       = 0;
  int                items_sent   = 0;
  int                results_seen = 0;
  int                cycles       = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Add elapsed ticks to a total, clamp at the maximum, count backward time as zero
  function automatic logic [TOTAL_W-1:0] add_dwell(logic [TOTAL_W-1:0] total,
                                                   logic [TIME_W-1:0] now,
                                                   logic [TIME_W-1:0] since);
    logic [TIME_W-1:0]  span;
    logic [TOTAL_W:0]   sum;
    span = (now > since) ? now - since : '0;
    sum  = {1'b0, total} + (TOTAL_W + 1)'(span);
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  // Fine bin that matches the tracked state, if any
  function automatic void fine_slot(output logic hit, output logic [INDEX_W-1:0] slot);
    int idx;
    hit = (cur_phase <= 2'd1) && (len_first <= FIRST_CAP) && (len_second <= SECOND_CAP)
          && (cur_batch <= BATCH_CAP);
    idx = ((int'({cur_phase[0], cur_queue}) * (FIRST_CAP + 1) + int'(len_first))
           * (SECOND_CAP + 1) + int'(len_second)) * (BATCH_CAP + 1) + int'(cur_batch);
    slot = hit ? INDEX_W'(idx) : '0;
  endfunction

  // Close bins that no longer match and open the matching ones at time now
  function automatic void rebin(logic [TIME_W-1:0] now);
    logic                has_coarse;
    logic                has_fine;
    logic [COARSE_W-1:0] coarse;
    logic [INDEX_W-1:0]  fine;
    has_coarse = (cur_phase <= 2'd1);
    coarse     = {cur_phase[0], cur_queue};
    fine_slot(has_fine, fine);
    if (!(coarse_open && has_coarse && coarse_bin == coarse)) begin
      if (coarse_open) begin
        coarse_total[coarse_bin] = add_dwell(coarse_total[coarse_bin], now, coarse_since);
      end
      coarse_open = has_coarse;
      if (has_coarse) begin
        coarse_bin   = coarse;
        coarse_since = now;
      end
    end
    if (!(fine_open && has_fine && fine_bin == fine)) begin
      if (fine_open) begin
        fine_total[fine_bin] = add_dwell(fine_total[fine_bin], now, fine_since);
        recent_fine = fine_bin;
      end
      fine_open = has_fine;
      if (has_fine) begin
        fine_bin   = fine;
        fine_since = now;
      end
    end
  endfunction

  // Advance the tracked state by one accepted transfer; queue the total a read returns
  function automatic void track_dwell(in_item_t item);
    out_item_t res;
    case (item.kind)
      KIND_PHASE: begin
        cur_phase = item.phase;
        cur_queue = item.queue_select;
        cur_batch = item.batch_size;
        rebin(item.event_time);
      end
      KIND_LENGTH: begin
        if (item.queue_select) len_second = item.queue_length;
        else len_first = item.queue_length;
        rebin(item.event_time);
      end
      KIND_READ: begin
        res = '0;
        if (!item.read_fine) begin
          if (item.read_index < COARSE_BINS) begin
            res.total_time = coarse_total[item.read_index[COARSE_W-1:0]];
            res.bin_open   = coarse_open && (coarse_bin == item.read_index[COARSE_W-1:0]);
          end
        end else if (item.read_index < FINE_BINS) begin
          res.total_time = fine_total[item.read_index];
          res.bin_open   = fine_open && (fine_bin == item.read_index);
        end
        res.saturated = (res.total_time == TOTAL_MAX);
        expected_totals = {expected_totals, res};
      end
      default: ;
    endcase
  endfunction

  // Offer one item after a random idle stretch and hold it until the transfer
  task automatic send_item(input in_item_t item);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    track_dwell(item);
    items_sent++;
  endtask

  task automatic send_phase(logic [TIME_W-1:0] at, logic [1:0] phase, logic queue,
                            logic [VALUE_W-1:0] batch);
    in_item_t item;
    item              = '0;
    item.kind         = KIND_PHASE;
    item.event_time   = at;
    item.phase        = phase;
    item.queue_select = queue;
    item.batch_size   = batch;
    send_item(item);
  endtask

  task automatic send_length(logic [TIME_W-1:0] at, logic queue, logic [VALUE_W-1:0] length);
    in_item_t item;
    item              = '0;
    item.kind         = KIND_LENGTH;
    item.event_time   = at;
    item.queue_select = queue;
    item.queue_length = length;
    send_item(item);
  endtask

  task automatic send_read(logic fine, logic [INDEX_W-1:0] index);
    in_item_t item;
    item            = '0;
    item.kind       = KIND_READ;
    item.event_time = stamp;
    item.read_fine  = fine;
    item.read_index = index;
    send_item(item);
  endtask

  // Drop valid, then wait for every queued total and let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random item: mostly well-formed updates and reads of live bins, some noise
  function automatic in_item_t random_event();
    in_item_t           item;
    int unsigned        roll;
    logic               hit;
    logic [INDEX_W-1:0] slot;
    item.phase        = 2'($urandom_range(3));
    item.queue_select = 1'($urandom_range(1));
    item.batch_size   = VALUE_W'($urandom_range(63));
    item.queue_length = VALUE_W'($urandom_range(63));
    item.read_fine    = 1'($urandom_range(1));
    item.read_index   = INDEX_W'($urandom_range(511));
    // mostly small steps forward, some large jumps, a few steps back
    roll = $urandom_range(99);
    if (roll < 80) stamp = stamp + TIME_W'($urandom_range(3000));
    else if (roll < 90) stamp = stamp + (TIME_W'($urandom) << $urandom_range(16));
    else if (roll < 96) stamp = stamp - TIME_W'($urandom_range(500));
    else stamp = TIME_W'({$urandom, $urandom});
    item.event_time = stamp;
    roll = $urandom_range(99);
    if (roll < 36) begin
      item.kind = KIND_PHASE;
      if ($urandom_range(99) < 85) item.phase = 2'($urandom_range(1));
      if ($urandom_range(99) < 85) item.batch_size = VALUE_W'($urandom_range(BATCH_CAP));
    end else if (roll < 70) begin
      item.kind = KIND_LENGTH;
      if ($urandom_range(99) < 85) begin
        item.queue_length =
          VALUE_W'($urandom_range(item.queue_select ? SECOND_CAP : FIRST_CAP));
      end
    end else if (roll < 98) begin
      item.kind = KIND_READ;
      fine_slot(hit, slot);
      roll = $urandom_range(99);
      if (!item.read_fine) begin
        if (roll < 85) item.read_index = INDEX_W'($urandom_range(COARSE_BINS - 1));
      end else if (roll < 40 && hit) begin
        item.read_index = slot;
      end else if (roll < 65) begin
        item.read_index = recent_fine;
      end else if (roll < 90) begin
        item.read_index = INDEX_W'($urandom_range(FINE_BINS - 1));
      end
    end else begin
      item.kind = KIND_NONE;
    end
    return item;
  endfunction

  // Walk through every kind, phase, capacity limit and read range by hand
  task automatic test_directed();
    in_item_t noop;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_read(1'b0, 0);
    send_phase(100, 2'd0, 1'b0, 0);
    send_read(1'b0, 0);
    send_length(150, 1'b0, 3);
    send_phase(400, 2'd1, 1'b1, 2);
    send_length(500, 1'b1, 63);
    send_phase(600, 2'd1, 1'b1, 63);
    send_phase(700, 2'd2, 1'b0, 0);
    send_phase(800, 2'd3, 1'b1, 0);
    send_phase(900, 2'd0, 1'b0, 0);
    send_length(950, 1'b1, 5);
    send_length(960, 1'b0, 0);
    // timestamp behind the open fine bin: closes it with zero elapsed fine time
    send_phase(920, 2'd1, 1'b0, 1);
    send_phase(LAST_TICK, 2'd0, 1'b1, 0);
    noop            = '0;
    noop.kind       = KIND_NONE;
    noop.event_time = 5;
    send_item(noop);
    for (int bin = 0; bin < COARSE_BINS; bin++) send_read(1'b0, INDEX_W'(bin));
    send_read(1'b0, INDEX_W'(COARSE_BINS));
    send_read(1'b0, '1);
    send_read(1'b1, 0);
    send_read(1'b1, INDEX_W'(FINE_BINS - 1));
    send_read(1'b1, INDEX_W'(FINE_BINS));
    send_read(1'b1, '1);
    stamp = LAST_TICK;
    drain_results();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_event());
    drain_results();
  endtask

  // Hold the result side off for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_ev;
    repeat (60) send_item(random_event());
    drain_results();
  endtask

  // Pile full-range dwell spans into one coarse and one fine bin until their totals clamp
  task automatic test_saturation();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_length(0, 1'b0, 0);
    send_length(0, 1'b1, 0);
    for (int lap = 0; lap < 260; lap++) begin
      send_phase(0, 2'd0, 1'b0, 1);
      send_phase(LAST_TICK, 2'd2, 1'b0, 1);
      if (lap % 64 == 63) begin
        send_read(1'b0, 0);
        send_read(1'b1, 1);
      end
    end
    send_read(1'b0, 0);
    send_read(1'b1, 1);
    drain_results();
  endtask

  // Count off the long receiver hold-off
  initial begin
    forever begin
      @(hold_off_ev);
      holding = 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  // Drive ready with random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest queued total
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (expected_totals.size() == 0) begin
        $error("unexpected result: total_time %0d", out_if.payload.total_time);
        errors++;
      end else begin
        want = expected_totals.pop_front();
        if (out_if.payload.total_time !== want.total_time) begin
          $error("total_time: expected %0d, got %0d", want.total_time,
                 out_if.payload.total_time);
          errors++;
        end
        if (out_if.payload.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated,
                 out_if.payload.saturated);
          errors++;
        end
        if (out_if.payload.bin_open !== want.bin_open) begin
          $error("bin_open: expected %0d, got %0d", want.bin_open, out_if.payload.bin_open);
          errors++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d totals outstanding", cycles,
               expected_totals.size());
      $display("status: fail");
      $finish;
    end
  end

  // Reset, then run the tests in turn
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    foreach (coarse_total[i]) coarse_total[i] = '0;
    foreach (fine_total[i]) fine_total[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(180, 0, 0);
    test_random(180, 67, 0);
    test_random(180, 0, 67);
    test_random(180, 33, 33);
    test_backpressure();
    test_saturation();
    if (expected_totals.size() != 0) begin
      $error("%0d expected totals never arrived", expected_totals.size());
      errors++;
    end
    $display("run covered %0d input transfers and %0d checked totals in %0d cycles",
             items_sent, results_seen, cycles);
    $display("with idle and stall mixes, a long output hold-off and total saturation");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
